FILE: rtl/tlsu_pkg.sv
`timescale 1ns / 1ps
package tlsu_pkg;

  localparam logic [4:0] K_REGWR = 5'd0;
  localparam logic [4:0] K_LDM   = 5'd1;
  localparam logic [4:0] K_STM   = 5'd2;
  localparam logic [4:0] K_POP   = 5'd3;
  localparam logic [4:0] K_PUSH  = 5'd4;
  localparam logic [4:0] K_LDRI  = 5'd5;
  localparam logic [4:0] K_LDRSP = 5'd6;
  localparam logic [4:0] K_LDRL  = 5'd7;
  localparam logic [4:0] K_LDRR  = 5'd8;
  localparam logic [4:0] K_LDRBI = 5'd9;
  localparam logic [4:0] K_LDRBR = 5'd10;
  localparam logic [4:0] K_LDRHI = 5'd11;
  localparam logic [4:0] K_LDRHR = 5'd12;
  localparam logic [4:0] K_LDRSB = 5'd13;
  localparam logic [4:0] K_LDRSH = 5'd14;
  localparam logic [4:0] K_STRI  = 5'd15;
  localparam logic [4:0] K_STRSP = 5'd16;
  localparam logic [4:0] K_STRR  = 5'd17;
  localparam logic [4:0] K_STRBI = 5'd18;
  localparam logic [4:0] K_STRBR = 5'd19;
  localparam logic [4:0] K_STRHI = 5'd20;
  localparam logic [4:0] K_STRHR = 5'd21;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  typedef struct packed {
    logic [3:0]  xreg;
    logic [31:0] value;
    logic [31:0] addr;
    logic        wr;
    logic        malf;
    logic        br;
    logic        last;
  } result_t;

endpackage

FILE: rtl/tlsu_ram.sv
`timescale 1ns / 1ps
module tlsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/thumb_load_store_unit_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_     | in  | tdata: kind, dest_reg, base_reg, offset_reg, imm_offset, register_mask,
//         |     |        pc_value, reg_index, write_data
// out_    | out | tdata: transfer_reg, transfer_value, mem_address; tuser: mem_write,
//         |     |        malformed, branch_taken; tlast: last_of_run
// After reset a clearing pass zeroes the data memory word by word; no input is taken
// during it. A register write is done on accept. A single load or store reads memory on
// accept and forms its result in the data state. A load-multiple or pop passes through
// a step and a data state per listed register and a closing base write-back step; a
// store-multiple or push handles each listed register in the step state alone.
// Output stalls hold the sequencer until the result register is free.
module thumb_load_store_unit_core
  import tlsu_pkg::*;
#(
  parameter int MEM_WORDS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // kind[4:0], dest_reg[7:5], base_reg[10:8], offset_reg[13:11], imm_offset[21:14],
  // register_mask[37:22], pc_value[69:38], reg_index[73:70], write_data[105:74]
  input  logic [111:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // transfer_reg[3:0], transfer_value[35:4], mem_address[67:36]
  output logic [71:0]   out_tdata,
  // mem_write[0], malformed[1], branch_taken[2]
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);
  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_STEP  = 5'b00100,
    S_DATA  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r;

  logic [31:0] lo_r [8];
  logic [31:0] sp_r, lr_r;

  logic [4:0]  kind_r;
  logic [2:0]  rd_r, rn_r;
  logic [15:0] list_r;
  logic [31:0] a_r;
  logic        any_r;
  logic [3:0]  cur_r;
  logic [31:0] ea_r;

  result_t res_r;
  logic    res_v_r;

  // Input fields.
  logic [4:0]  i_kind;
  logic [2:0]  i_rd, i_rn, i_rm;
  logic [7:0]  i_imm;
  logic [15:0] i_list;
  logic [31:0] i_pc, i_wd;
  logic [3:0]  i_ridx;
  assign i_kind = in_tdata[4:0];
  assign i_rd   = in_tdata[7:5];
  assign i_rn   = in_tdata[10:8];
  assign i_rm   = in_tdata[13:11];
  assign i_imm  = in_tdata[21:14];
  assign i_list = in_tdata[37:22];
  assign i_pc   = in_tdata[69:38];
  assign i_ridx = in_tdata[73:70];
  assign i_wd   = in_tdata[105:74];

  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  logic res_free;
  assign res_free = !res_v_r || out_tready;

  logic res_load;

  // Memory port.
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [31:0]   m_wdata, m_rdata;

  tlsu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // Effective address of a single access.
  logic [31:0] ea_c;
  always_comb begin
    case (i_kind)
      K_LDRI, K_STRI:   ea_c = lo_r[i_rn] + {22'd0, i_imm, 2'b00};
      K_LDRSP, K_STRSP: ea_c = sp_r + {22'd0, i_imm, 2'b00};
      K_LDRL:           ea_c = {i_pc[31:2], 2'b00} + {22'd0, i_imm, 2'b00};
      K_LDRBI, K_STRBI: ea_c = lo_r[i_rn] + {24'd0, i_imm};
      K_LDRHI, K_STRHI: ea_c = lo_r[i_rn] + {23'd0, i_imm, 1'b0};
      default:          ea_c = lo_r[i_rn] + lo_r[i_rm];
    endcase
  end

  // Next register of a multiple transfer: lowest pending bit, or highest for push.
  // Bit 8 of the list only flags a listed ldm base and is never a register.
  logic [15:0] pend;
  logic        pend_any;
  logic [3:0]  pick;
  always_comb begin
    pend = list_r & 16'hC0FF;
    pend_any = |pend;
    pick = '0;
    if (kind_r == K_PUSH) begin
      for (int i = 0; i < 16; i++) begin
        if (pend[i]) pick = 4'(i);
      end
    end else begin
      for (int i = 15; i >= 0; i--) begin
        if (pend[i]) pick = 4'(i);
      end
    end
  end

  logic [31:0] step_addr;
  assign step_addr = (kind_r == K_PUSH) ? a_r - 32'd4 : a_r;

  // Load extraction and store merge on the word read back.
  logic [31:0] ld_v, st_v, d_v;
  logic [7:0]  byte_v;
  logic [15:0] half_v;
  always_comb begin
    byte_v = 8'(m_rdata >> {ea_r[1:0], 3'b000});
    half_v = ea_r[1] ? m_rdata[31:16] : m_rdata[15:0];
    case (kind_r)
      K_LDRBI, K_LDRBR: ld_v = {24'd0, byte_v};
      K_LDRSB:          ld_v = {{24{byte_v[7]}}, byte_v};
      K_LDRHI, K_LDRHR: ld_v = {16'd0, half_v};
      K_LDRSH:          ld_v = {{16{half_v[15]}}, half_v};
      default:          ld_v = m_rdata;
    endcase
    d_v = lo_r[rd_r];
    case (kind_r)
      K_STRBI, K_STRBR: begin
        st_v = (m_rdata & ~(32'hFF << {ea_r[1:0], 3'b000}))
             | ({24'd0, d_v[7:0]} << {ea_r[1:0], 3'b000});
      end
      K_STRHI, K_STRHR: begin
        st_v = ea_r[1] ? {d_v[15:0], m_rdata[15:0]} : {m_rdata[31:16], d_v[15:0]};
      end
      default: st_v = d_v;
    endcase
  end

  logic [31:0] stval;
  assign stval = (pick == REG_LR) ? lr_r : lo_r[pick[2:0]];

  always_comb begin
    state_nxt = state_r;
    m_we = 1'b0;
    m_waddr = ea_r[AW+1:2];
    m_wdata = '0;
    m_raddr = ea_c[AW+1:2];
    res_load = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        m_we = 1'b1;
        m_waddr = clr_r;
        if (clr_r == AW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (i_kind >= K_LDM && i_kind <= K_PUSH) state_nxt = S_STEP;
          else if (i_kind >= K_LDRI && i_kind <= K_STRHR) state_nxt = S_DATA;
        end
      end
      S_STEP: begin
        m_raddr = step_addr[AW+1:2];
        if (!pend_any) state_nxt = S_IDLE;
        else if (kind_r == K_STM && !any_r && pick[2:0] == rn_r) begin
          if (res_free) begin
            state_nxt = S_IDLE;
            res_load = 1'b1;
          end
        end else if (kind_r == K_LDM || kind_r == K_POP) state_nxt = S_DATA;
        else if (res_free) begin
          m_we = 1'b1;
          m_waddr = step_addr[AW+1:2];
          m_wdata = stval;
          res_load = 1'b1;
        end
      end
      S_DATA: begin
        // Keep reading the same word so a stalled result still sees its data.
        m_raddr = ea_r[AW+1:2];
        if (res_free) begin
          res_load = 1'b1;
          if (kind_r >= K_STRI) begin
            m_we = 1'b1;
            m_wdata = st_v;
          end
          state_nxt = (kind_r == K_LDM || kind_r == K_POP) ? S_STEP : S_IDLE;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      res_v_r <= 1'b0;
      sp_r <= '0;
      lr_r <= '0;
      for (int i = 0; i < 8; i++) lo_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_load) res_v_r <= 1'b1;
      else if (out_tready) res_v_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          if (accept) begin
            kind_r <= i_kind;
            rd_r <= i_rd;
            rn_r <= i_rn;
            any_r <= 1'b0;
            ea_r <= ea_c;
            case (i_kind)
              K_LDM:  begin list_r <= {8'd0, i_list[7:0]}; a_r <= lo_r[i_rn]; end
              K_STM:  begin list_r <= {8'd0, i_list[7:0]}; a_r <= lo_r[i_rn]; end
              K_POP:  begin list_r <= {i_list[15], 7'd0, i_list[7:0]}; a_r <= sp_r; end
              K_PUSH: begin list_r <= {1'b0, i_list[14], 6'd0, i_list[7:0]}; a_r <= sp_r; end
              default: list_r <= '0;
            endcase
            if (i_kind == K_REGWR) begin
              if (i_ridx < 4'd8) lo_r[i_ridx[2:0]] <= i_wd;
              else if (i_ridx == REG_SP) sp_r <= i_wd;
              else if (i_ridx == REG_LR) lr_r <= i_wd;
            end
          end
        end
        S_STEP: begin
          if (!pend_any) begin
            if (kind_r == K_LDM) begin
              if (!list_r[8]) lo_r[rn_r] <= a_r;
            end else if (kind_r == K_STM) lo_r[rn_r] <= a_r;
            else sp_r <= a_r;
          end else if (kind_r == K_STM && !any_r && pick[2:0] == rn_r) begin
            if (res_free) begin
              res_r <= '{xreg: {1'b0, rn_r}, value: '0, addr: a_r, wr: 1'b0,
                         malf: 1'b1, br: 1'b0, last: 1'b1};
            end
          end else if (kind_r == K_LDM || kind_r == K_POP) begin
            cur_r <= pick;
            ea_r <= a_r;
            a_r <= a_r + 32'd4;
            // Remember that the base was listed, for the ldm write-back rule.
            list_r <= (list_r & ~(16'd1 << pick))
                    | ((kind_r == K_LDM && pick[2:0] == rn_r) ? 16'h0100 : 16'h0000);
          end else if (res_free) begin
            cur_r <= pick;
            any_r <= 1'b1;
            a_r <= step_addr + ((kind_r == K_STM) ? 32'd4 : 32'd0);
            list_r[pick] <= 1'b0;
            res_r <= '{xreg: pick, value: stval, addr: step_addr, wr: 1'b1,
                       malf: 1'b0, br: 1'b0, last: ($countones(list_r) == 1)};
          end
        end
        S_DATA: begin
          if (res_free) begin
            if (kind_r == K_LDM || kind_r == K_POP) begin
              if (cur_r != REG_PC) lo_r[cur_r[2:0]] <= m_rdata;
              res_r <= '{xreg: cur_r, value: m_rdata, addr: ea_r, wr: 1'b0, malf: 1'b0,
                         br: (cur_r == REG_PC),
                         last: ((list_r & 16'h80FF) == 16'd0)};
            end else if (kind_r >= K_STRI) begin
              res_r <= '{xreg: {1'b0, rd_r}, value: st_v, addr: ea_r, wr: 1'b1,
                         malf: 1'b0, br: 1'b0, last: 1'b1};
            end else begin
              lo_r[rd_r] <= ld_v;
              res_r <= '{xreg: {1'b0, rd_r}, value: ld_v, addr: ea_r, wr: 1'b0,
                         malf: 1'b0, br: 1'b0, last: 1'b1};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {4'd0, res_r.addr, res_r.value, res_r.xreg};
  assign out_tuser  = {res_r.br, res_r.malf, res_r.wr};
  assign out_tlast  = res_r.last;
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import tlsu_pkg::*;

  localparam int MEM_WORDS = 4096;
  localparam int N_RANDOM = 308;

  typedef struct {
    logic [4:0]  kind;
    logic [2:0]  rd;
    logic [2:0]  rn;
    logic [2:0]  rm;
    logic [7:0]  imm;
    logic [15:0] list;
    logic [31:0] pc;
    logic [3:0]  ridx;
    logic [31:0] wdata;
    bit          drain;
  } instr_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  // Shadow copy of the architectural state.
  logic [31:0] lo_regs [8];
  logic [31:0] sp_q, lr_q;
  logic [31:0] dmem [MEM_WORDS];

  instr_t  instr_q[$];
  result_t results_q[$];
  int      n_errors = 0;
  int      n_results = 0;
  int      hold_left = 0;
  bit      hold_done = 0;

  thumb_load_store_unit_core #(.MEM_WORDS(MEM_WORDS)) DUT (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int word_of(logic [31:0] a);
    return (a >> 2) % MEM_WORDS;
  endfunction

  function automatic void add_result(logic [3:0] r, logic [31:0] v, logic [31:0] a,
                                     logic w, logic m, logic b);
    result_t e;
    e.xreg = r; e.value = v; e.addr = a; e.wr = w; e.malf = m; e.br = b; e.last = 1'b0;
    results_q.push_back(e);
  endfunction

  function automatic void execute_instr(instr_t t);
    logic [31:0] a, v, w, d, ea;
    int n;
    int sh;
    n = 0;
    case (t.kind)
      K_REGWR: begin
        if (t.ridx < 4'd8) lo_regs[t.ridx[2:0]] = t.wdata;
        else if (t.ridx == REG_SP) sp_q = t.wdata;
        else if (t.ridx == REG_LR) lr_q = t.wdata;
      end
      K_LDM: begin
        a = lo_regs[t.rn];
        for (int i = 0; i < 8; i++) begin
          if (t.list[i]) begin
            v = dmem[word_of(a)];
            lo_regs[i] = v;
            add_result(4'(i), v, a, 1'b0, 1'b0, 1'b0);
            n++;
            a += 4;
          end
        end
        if (!t.list[t.rn]) lo_regs[t.rn] = a;
      end
      K_STM: begin
        a = lo_regs[t.rn];
        for (int i = 0; i < 8; i++) begin
          if (t.list[i]) begin
            // The base as lowest listed register aborts with a single flagged result.
            if (n == 0 && i == t.rn) begin
              add_result({1'b0, t.rn}, 32'd0, a, 1'b0, 1'b1, 1'b0);
              results_q[results_q.size() - 1].last = 1'b1;
              return;
            end
            v = lo_regs[i];
            dmem[word_of(a)] = v;
            add_result(4'(i), v, a, 1'b1, 1'b0, 1'b0);
            n++;
            a += 4;
          end
        end
        lo_regs[t.rn] = a;
      end
      K_POP: begin
        a = sp_q;
        for (int i = 0; i < 8; i++) begin
          if (t.list[i]) begin
            v = dmem[word_of(a)];
            lo_regs[i] = v;
            add_result(4'(i), v, a, 1'b0, 1'b0, 1'b0);
            n++;
            a += 4;
          end
        end
        if (t.list[15]) begin
          add_result(REG_PC, dmem[word_of(a)], a, 1'b0, 1'b0, 1'b1);
          n++;
          a += 4;
        end
        sp_q = a;
      end
      K_PUSH: begin
        a = sp_q;
        if (t.list[14]) begin
          a -= 4;
          dmem[word_of(a)] = lr_q;
          add_result(REG_LR, lr_q, a, 1'b1, 1'b0, 1'b0);
          n++;
        end
        for (int i = 7; i >= 0; i--) begin
          if (t.list[i]) begin
            a -= 4;
            dmem[word_of(a)] = lo_regs[i];
            add_result(4'(i), lo_regs[i], a, 1'b1, 1'b0, 1'b0);
            n++;
          end
        end
        sp_q = a;
      end
      default: begin
        if (t.kind <= K_STRHR) begin
          case (t.kind)
            K_LDRI, K_STRI:   ea = lo_regs[t.rn] + {22'd0, t.imm, 2'b00};
            K_LDRSP, K_STRSP: ea = sp_q + {22'd0, t.imm, 2'b00};
            K_LDRL:           ea = {t.pc[31:2], 2'b00} + {22'd0, t.imm, 2'b00};
            K_LDRBI, K_STRBI: ea = lo_regs[t.rn] + {24'd0, t.imm};
            K_LDRHI, K_STRHI: ea = lo_regs[t.rn] + {23'd0, t.imm, 1'b0};
            default:          ea = lo_regs[t.rn] + lo_regs[t.rm];
          endcase
          w = dmem[word_of(ea)];
          sh = ea[1:0] * 8;
          if (t.kind <= K_LDRSH) begin
            if (t.kind <= K_LDRR) begin
              v = w;
            end else if (t.kind == K_LDRBI || t.kind == K_LDRBR || t.kind == K_LDRSB) begin
              v = (w >> sh) & 32'hFF;
              if (t.kind == K_LDRSB) v = {{24{v[7]}}, v[7:0]};
            end else begin
              v = ea[1] ? (w >> 16) : (w & 32'hFFFF);
              if (t.kind == K_LDRSH) v = {{16{v[15]}}, v[15:0]};
            end
            lo_regs[t.rd] = v;
            add_result({1'b0, t.rd}, v, ea, 1'b0, 1'b0, 1'b0);
          end else begin
            d = lo_regs[t.rd];
            if (t.kind <= K_STRR) v = d;
            else if (t.kind <= K_STRBR) v = (w & ~(32'hFF << sh)) | ((d & 32'hFF) << sh);
            else if (ea[1]) v = (w & 32'hFFFF) | {d[15:0], 16'd0};
            else v = (w & 32'hFFFF0000) | {16'd0, d[15:0]};
            dmem[word_of(ea)] = v;
            add_result({1'b0, t.rd}, v, ea, 1'b1, 1'b0, 1'b0);
          end
          n = 1;
        end
      end
    endcase
    if (n > 0) results_q[results_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h, expected %h", $realtime, field, got, want);
    n_errors++;
  endtask

  // Draws an idle count, with occasional bursts of back-to-back transfers.
  function automatic int draw_wait(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) burst = $urandom_range(10, 30);
    return $urandom_range(0, 8);
  endfunction

  // Sender.
  instr_t cur;
  int     in_gap = 0;
  int     in_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) execute_instr(cur);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (instr_q.size() > 0 && !(instr_q[0].drain && results_q.size() > 0)) begin
          cur = instr_q.pop_front();
          in_tdata <= {6'd0, cur.wdata, cur.ridx, cur.pc, cur.list, cur.imm,
                       cur.rm, cur.rn, cur.rd, cur.kind};
          in_tvalid <= 1'b1;
          in_gap = draw_wait(in_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, so the block backs up into its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= 120) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Receiver and checker.
  int out_wait = 0;
  int out_burst = 0;
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (results_q.size() == 0) begin
          report("unexpected transfer_reg", 32'(out_tdata[3:0]), 32'd0);
        end else begin
          e = results_q.pop_front();
          if (out_tdata[3:0] !== e.xreg)
            report("transfer_reg", 32'(out_tdata[3:0]), 32'(e.xreg));
          if (out_tdata[35:4] !== e.value) report("transfer_value", out_tdata[35:4], e.value);
          if (out_tdata[67:36] !== e.addr) report("mem_address", out_tdata[67:36], e.addr);
          if (out_tuser[0] !== e.wr) report("mem_write", 32'(out_tuser[0]), 32'(e.wr));
          if (out_tuser[1] !== e.malf) report("malformed", 32'(out_tuser[1]), 32'(e.malf));
          if (out_tuser[2] !== e.br) report("branch_taken", 32'(out_tuser[2]), 32'(e.br));
          if (out_tlast !== e.last) report("last_of_run", 32'(out_tlast), 32'(e.last));
        end
        out_wait = draw_wait(out_burst);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_tready <= (out_wait == 0) && (hold_left == 0);
    end
  end

  function automatic instr_t mk(logic [4:0] k, logic [2:0] rd, logic [2:0] rn,
                                logic [2:0] rm, logic [7:0] imm, logic [15:0] list);
    instr_t t;
    t.kind = k; t.rd = rd; t.rn = rn; t.rm = rm; t.imm = imm; t.list = list;
    t.pc = $urandom; t.ridx = 4'($urandom); t.wdata = $urandom; t.drain = 0;
    return t;
  endfunction

  function automatic instr_t mk_wr(logic [3:0] idx, logic [31:0] val);
    instr_t t;
    t = mk(K_REGWR, 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
           16'($urandom));
    t.ridx = idx;
    t.wdata = val;
    return t;
  endfunction

  initial begin
    instr_t t;
    int sel;
    foreach (lo_regs[i]) lo_regs[i] = '0;
    sp_q = '0;
    lr_q = '0;
    foreach (dmem[i]) dmem[i] = '0;

    instr_q.push_back(mk_wr(4'd0, 32'h100));
    instr_q.push_back(mk_wr(4'd1, 32'hFFFF_FFFF));
    instr_q.push_back(mk_wr(REG_SP, 32'h200));
    instr_q.push_back(mk_wr(REG_LR, 32'hDEAD_BEEF));
    instr_q.push_back(mk_wr(4'd9, 32'h1234_5678));
    instr_q.push_back(mk_wr(REG_PC, 32'h0));
    instr_q.push_back(mk(K_PUSH, 3'd0, 3'd0, 3'd0, 8'd0, 16'hFFFF));
    instr_q.push_back(mk(K_POP, 3'd0, 3'd0, 3'd0, 8'd0, 16'hFFFF));
    instr_q.push_back(mk_wr(4'd0, 32'h40));
    instr_q.push_back(mk(K_STM, 3'd0, 3'd0, 3'd0, 8'd0, 16'h0001));
    instr_q.push_back(mk_wr(4'd2, 32'h80));
    instr_q.push_back(mk(K_STM, 3'd0, 3'd2, 3'd0, 8'd0, 16'hFF0F));
    instr_q.push_back(mk(K_LDM, 3'd0, 3'd3, 3'd0, 8'd0, 16'h0009));
    instr_q.push_back(mk(K_LDM, 3'd0, 3'd4, 3'd0, 8'd0, 16'hFF00));
    instr_q.push_back(mk(K_STRI, 3'd1, 3'd0, 3'd0, 8'hFF, 16'd0));
    instr_q.push_back(mk(K_STRBR, 3'd1, 3'd0, 3'd2, 8'd0, 16'd0));
    instr_q.push_back(mk(K_STRHI, 3'd1, 3'd0, 3'd0, 8'h01, 16'd0));
    instr_q.push_back(mk(K_LDRSB, 3'd5, 3'd0, 3'd2, 8'd0, 16'd0));
    instr_q.push_back(mk(K_LDRSH, 3'd6, 3'd0, 3'd0, 8'd0, 16'd0));
    t = mk(K_LDRL, 3'd7, 3'd0, 3'd0, 8'hFF, 16'd0);
    t.pc = 32'hFFFF_FFFF;
    instr_q.push_back(t);
    instr_q.push_back(mk(5'd31, 3'd0, 3'd0, 3'd0, 8'd0, 16'd0));
    instr_q.push_back(mk(5'd22, 3'd0, 3'd0, 3'd0, 8'd0, 16'd0));

    for (int i = 0; i < N_RANDOM; i++) begin
      t = mk(5'($urandom), 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
             16'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        t.kind = K_REGWR;
        // Mostly small addresses so accesses hit the same words again.
        if ($urandom_range(0, 9) < 7) t.wdata = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) != 0) t.ridx = $urandom_range(0, 9) < 8 ?
                                          4'($urandom_range(0, 7)) : REG_SP;
      end else if (sel < 42) begin
        t.kind = 5'($urandom_range(K_LDM, K_PUSH));
      end else if (sel < 95) begin
        t.kind = 5'($urandom_range(K_LDRI, K_STRHR));
      end else begin
        t.kind = 5'($urandom_range(22, 31));
      end
      t.drain = (i == 200);
      instr_q.push_back(t);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (instr_q.size() > 0 || in_tvalid);
    do @(posedge clk); while (results_q.size() > 0);
    repeat (40) @(posedge clk);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
